>>> sv/ire_pkg.sv
package ire_pkg;

    localparam int VAL_W = 12;
    localparam int SYM_W = 7;
    localparam int AMT_W = 10;
    localparam int PC_W  = 5;

    // ASCII letters of the numeral
    localparam logic [SYM_W-1:0] SYM_C = 7'h43;
    localparam logic [SYM_W-1:0] SYM_D = 7'h44;
    localparam logic [SYM_W-1:0] SYM_I = 7'h49;
    localparam logic [SYM_W-1:0] SYM_L = 7'h4C;
    localparam logic [SYM_W-1:0] SYM_M = 7'h4D;
    localparam logic [SYM_W-1:0] SYM_V = 7'h56;
    localparam logic [SYM_W-1:0] SYM_X = 7'h58;

    typedef enum logic {
        COND_ALWAYS,
        COND_GE
    } cond_t;

    // One control word: test, letter to emit, whether to subtract, pair flag, amount and jumps
    typedef struct packed {
        cond_t             cond;
        logic [SYM_W-1:0]  letter;
        logic              sub;
        logic              pair_first;
        logic [AMT_W-1:0]  amount;
        logic [PC_W-1:0]   next_pass;
        logic [PC_W-1:0]   next_fail;
    } uword_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic pass;
        logic zero_after;
    } dp_status_t;

    // Letter handed from the sequencer to the output stage
    typedef struct packed {
        logic             fire;
        logic [SYM_W-1:0] letter;
        logic             last;
        logic             busy;
    } seq_out_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            5'd0:    w = '{COND_GE,     SYM_M, 1'b1, 1'b0, 10'd1000, 5'd0,  5'd1};
            5'd1:    w = '{COND_GE,     SYM_C, 1'b0, 1'b1, 10'd900,  5'd2,  5'd3};
            5'd2:    w = '{COND_ALWAYS, SYM_M, 1'b1, 1'b0, 10'd900,  5'd3,  5'd3};
            5'd3:    w = '{COND_GE,     SYM_D, 1'b1, 1'b0, 10'd500,  5'd4,  5'd4};
            5'd4:    w = '{COND_GE,     SYM_C, 1'b0, 1'b1, 10'd400,  5'd5,  5'd6};
            5'd5:    w = '{COND_ALWAYS, SYM_D, 1'b1, 1'b0, 10'd400,  5'd6,  5'd6};
            5'd6:    w = '{COND_GE,     SYM_C, 1'b1, 1'b0, 10'd100,  5'd6,  5'd7};
            5'd7:    w = '{COND_GE,     SYM_X, 1'b0, 1'b1, 10'd90,   5'd8,  5'd9};
            5'd8:    w = '{COND_ALWAYS, SYM_C, 1'b1, 1'b0, 10'd90,   5'd9,  5'd9};
            5'd9:    w = '{COND_GE,     SYM_L, 1'b1, 1'b0, 10'd50,   5'd10, 5'd10};
            5'd10:   w = '{COND_GE,     SYM_X, 1'b0, 1'b1, 10'd40,   5'd11, 5'd12};
            5'd11:   w = '{COND_ALWAYS, SYM_L, 1'b1, 1'b0, 10'd40,   5'd12, 5'd12};
            5'd12:   w = '{COND_GE,     SYM_X, 1'b1, 1'b0, 10'd10,   5'd12, 5'd13};
            5'd13:   w = '{COND_GE,     SYM_I, 1'b0, 1'b1, 10'd9,    5'd14, 5'd15};
            5'd14:   w = '{COND_ALWAYS, SYM_X, 1'b1, 1'b0, 10'd9,    5'd15, 5'd15};
            5'd15:   w = '{COND_GE,     SYM_V, 1'b1, 1'b0, 10'd5,    5'd16, 5'd16};
            5'd16:   w = '{COND_GE,     SYM_I, 1'b0, 1'b1, 10'd4,    5'd17, 5'd18};
            5'd17:   w = '{COND_ALWAYS, SYM_V, 1'b1, 1'b0, 10'd4,    5'd18, 5'd18};
            5'd18:   w = '{COND_GE,     SYM_I, 1'b1, 1'b0, 10'd1,    5'd18, 5'd18};
            default: w = '{COND_GE,     SYM_I, 1'b1, 1'b0, 10'd1,    5'd18, 5'd18};
        endcase
        return w;
    endfunction

endpackage

>>> sv/ire_dp.sv
module ire_dp
    import ire_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic [VAL_W-1:0] value,
    input  logic             advance,
    input  uword_t           uw,
    output dp_status_t       status
);

    logic [VAL_W-1:0] rest_reg;
    logic [VAL_W-1:0] rest_next;
    logic [VAL_W-1:0] amount_ext;
    logic [VAL_W-1:0] rest_after;

    assign amount_ext = {{(VAL_W-AMT_W){1'b0}}, uw.amount};
    assign rest_after = uw.sub ? (rest_reg - amount_ext) : rest_reg;

    assign status.pass       = (uw.cond == COND_ALWAYS) || (rest_reg >= amount_ext);
    assign status.zero_after = (rest_after == '0);

    always_comb
    begin
        rest_next = rest_reg;
        if (load)
        begin
            rest_next = value;
        end
        else if (advance)
        begin
            rest_next = rest_after;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
    end

endmodule

>>> sv/ire_seq.sv
module ire_seq
    import ire_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       value_nonzero,
    input  logic       out_free,
    input  dp_status_t status,
    output uword_t     uw,
    output logic       advance,
    output seq_out_t   so
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    logic            step_go;
    logic            last;

    assign uw = ucode(pc_reg);

    // a failing test needs no output slot; an emitting one does
    assign step_go = busy_reg && (!status.pass || out_free);
    assign last    = !uw.pair_first && status.zero_after;
    assign advance = step_go && status.pass && uw.sub;

    assign so.fire   = step_go && status.pass;
    assign so.letter = uw.letter;
    assign so.last   = last;
    assign so.busy   = busy_reg;

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (load)
        begin
            pc_next   = '0;
            busy_next = value_nonzero;
        end
        else if (step_go)
        begin
            pc_next = status.pass ? uw.next_pass : uw.next_fail;
            if (status.pass && last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

>>> sv/int_to_roman_encoder_core.sv
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   value[11:0]
// output    out        out_valid/out_stall symbol[6:0], last
//
// One program step per cycle after the cycle that takes the item, while an output stall
// holds no emitting step: a value needs one step per letter plus one per failing test,
// at most 24 (3888), as the microprogram sets; no new item is taken before the last letter.
// A value of zero is consumed when it is taken and produces nothing.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// An output stall freezes the sequencer on its next emitting step only.
module int_to_roman_encoder_core
    import ire_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [VAL_W-1:0] value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SYM_W-1:0] symbol,
    output logic             last
);

    uword_t     uw;
    dp_status_t status;
    seq_out_t   so;
    logic       advance;
    logic       load;
    logic       out_free;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [SYM_W-1:0] symbol_reg;
    logic             last_reg;

    // take a new item as soon as the sequencer has issued the last letter
    assign in_stall = so.busy;
    assign load     = in_valid && !so.busy;

    // the output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    ire_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .value_nonzero (value != '0),
        .out_free      (out_free),
        .status        (status),
        .uw            (uw),
        .advance       (advance),
        .so            (so)
    );

    ire_dp u_dp (
        .clk     (clk),
        .load    (load),
        .value   (value),
        .advance (advance),
        .uw      (uw),
        .status  (status)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (so.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the letter until it is taken
    always_ff @(posedge clk)
    begin
        if (so.fire)
        begin
            symbol_reg <= so.letter;
            last_reg   <= so.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

endmodule
